### design/per_flow_interval_byte_history_unit_defines.svh
// Assertion macros for the per-flow interval byte history unit.
`ifndef PER_FLOW_INTERVAL_BYTE_HISTORY_UNIT_DEFINES_SVH
`define PER_FLOW_INTERVAL_BYTE_HISTORY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// prop holds at every rising clock edge outside reset
`define PFIBH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expr is never true outside reset
`define PFIBH_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PFIBH_ASSERT(lbl, clk, rstn, prop, msg)
`define PFIBH_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

### design/pfibh_pkg.sv
// Types and constants of the per-flow interval byte history unit.
package pfibh_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER   = 3'd0,
        OP_UNREGISTER = 3'd1,
        OP_ADD        = 3'd2,
        OP_TICK       = 3'd3,
        OP_QUERY_FLOW = 3'd4,
        OP_QUERY_ALL  = 3'd5,
        OP_CLEAR_ALL  = 3'd6
    } op_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [31:0] BUCKET_ID         = 32'hFFFF_FFFF;
    localparam logic [6:0]  INTERVALS_DEFAULT = 7'd60;

endpackage

### design/per_flow_interval_byte_history_unit.sv
// Per-flow interval byte history: flow table, slot ring memory and operation sequencer.
// One operation is taken at a time; s_tready is low until its last result beat has gone.
// A flow lookup scans the table one entry a cycle. Add, tick, an unregister fold, a flow
// query and a total query all go through the ring memory, which has one read and one write
// port; every result beat is then held in the output register until it is taken. Writing
// to a flow ring that was registered or cleared first zeroes its row. Before a query the
// start slot is reduced by repeated subtraction. Rings are marked clean per flow, so reset
// and clear all need no sweep of the memory.
`include "per_flow_interval_byte_history_unit_defines.svh"
module per_flow_interval_byte_history_unit #(
    parameter int MAX_FLOWS = 16,
    parameter int MAX_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // flow_id[31:0], byte_count[63:32]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot_total[31:0], slot_position[37:32], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    localparam int FW   = $clog2(MAX_FLOWS);
    localparam int SW   = $clog2(MAX_SLOTS);
    localparam int CW   = SW + 1;
    localparam int AW   = FW + SW;
    localparam int NMAX = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCAN, ST_DISPATCH, ST_ZSWEEP, ST_ADD_RD, ST_ADD_WR,
        ST_FOLD_SRC, ST_FOLD_DST, ST_FOLD_WR, ST_TICK, ST_REDUCE,
        ST_QF_RD, ST_QF_DAT, ST_QT_RD, ST_QT_ACC, ST_EMIT
    } state_t;

    state_t            state_reg, state_next, ret_reg, ret_next;
    pfibh_pkg::op_t    op_reg, op_next;
    logic [31:0]       id_reg, id_next, bytes_reg, bytes_next;
    logic [31:0]       keys_reg [MAX_FLOWS];
    logic [31:0]       keys_next [MAX_FLOWS];
    logic [MAX_FLOWS-1:0] valid_reg, valid_next, clean_reg, clean_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [6:0]        cfg_reg, cfg_next;
    logic [FW:0]       scan_reg, scan_next;
    logic              hit_reg, hit_next, free_reg, free_next, bkt_reg, bkt_next;
    logic [FW-1:0]     hit_f_reg, hit_f_next, free_f_reg, free_f_next;
    logic [FW-1:0]     bkt_f_reg, bkt_f_next, zrow_reg, zrow_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [6:0]        s_reg, s_next;
    logic [5:0]        pos_reg, pos_next;
    logic [31:0]       sum_reg, sum_next, src_reg, src_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [31:0]       m_total_reg, m_total_next;
    logic [5:0]        m_pos_reg, m_pos_next;
    logic [1:0]        m_status_reg, m_status_next;

    // one row of 2**SW words per flow, addressed as {flow, slot}
    logic [31:0]       slot_mem [MAX_FLOWS*(2**SW)];
    logic [31:0]       rdata_reg;
    logic [AW-1:0]     raddr, waddr;
    logic [31:0]       wdata;
    logic              we;

    logic [6:0]        n7;
    logic [CW-1:0]     n_c;
    logic [6:0]        cur_inc, s_inc;
    logic [FW-1:0]     scan_idx;
    logic              scan_last, q_last;

    assign n7 = (cfg_reg < 7'd2) ? 7'd2 : ((cfg_reg > 7'(NMAX)) ? 7'(NMAX) : cfg_reg);
    assign n_c       = CW'(n7);
    assign cur_inc   = 7'(cur_reg) + 7'd1;
    assign s_inc     = s_reg + 7'd1;
    assign scan_idx  = scan_reg[FW-1:0];
    assign scan_last = (scan_reg == (FW+1)'(MAX_FLOWS - 1));
    assign q_last    = ({1'b0, pos_reg} == (n7 - 7'd1));

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_pos_reg, m_total_reg};
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        bytes_next   = bytes_reg;
        keys_next    = keys_reg;
        valid_next   = valid_reg;
        clean_next   = clean_reg;
        cur_next     = cur_reg;
        cfg_next     = cfg_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        hit_f_next   = hit_f_reg;
        free_next    = free_reg;
        free_f_next  = free_f_reg;
        bkt_next     = bkt_reg;
        bkt_f_next   = bkt_f_reg;
        zrow_next    = zrow_reg;
        cnt_next     = cnt_reg;
        s_next       = s_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        src_next     = src_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        m_total_next = m_total_reg;
        m_pos_next   = m_pos_reg;
        m_status_next = m_status_reg;
        raddr = '0;
        waddr = '0;
        wdata = '0;
        we    = 1'b0;

        if (cfg_valid) begin
            cfg_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = pfibh_pkg::op_t'(s_tuser);
                    id_next    = s_tdata[31:0];
                    bytes_next = s_tdata[63:32];
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    bkt_next   = 1'b0;
                    if (s_tuser == pfibh_pkg::OP_REGISTER || s_tuser == pfibh_pkg::OP_UNREGISTER
                        || s_tuser == pfibh_pkg::OP_ADD
                        || s_tuser == pfibh_pkg::OP_QUERY_FLOW) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DISPATCH;
                    end
                end
            end
            ST_SCAN: begin
                // lowest index wins for each of the three searches
                if (valid_reg[scan_idx] && keys_reg[scan_idx] == id_reg && !hit_reg) begin
                    hit_next   = 1'b1;
                    hit_f_next = scan_idx;
                end
                if (!valid_reg[scan_idx] && !free_reg) begin
                    free_next   = 1'b1;
                    free_f_next = scan_idx;
                end
                if (valid_reg[scan_idx] && keys_reg[scan_idx] == pfibh_pkg::BUCKET_ID
                    && !bkt_reg) begin
                    bkt_next   = 1'b1;
                    bkt_f_next = scan_idx;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_last) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                m_total_next  = '0;
                m_pos_next    = '0;
                m_last_next   = 1'b1;
                m_status_next = pfibh_pkg::STATUS_OK;
                cnt_next      = '0;
                scan_next     = '0;
                case (op_reg)
                    pfibh_pkg::OP_REGISTER: begin
                        m_valid_next = 1'b1;
                        state_next   = ST_EMIT;
                        if (hit_reg) begin
                            clean_next[hit_f_reg] = 1'b1;
                        end else if (free_reg) begin
                            valid_next[free_f_reg] = 1'b1;
                            keys_next[free_f_reg]  = id_reg;
                            clean_next[free_f_reg] = 1'b1;
                        end else begin
                            m_status_next = pfibh_pkg::STATUS_FULL;
                        end
                    end
                    pfibh_pkg::OP_UNREGISTER: begin
                        if (!hit_reg) begin
                            m_status_next = pfibh_pkg::STATUS_UNKNOWN;
                            m_valid_next  = 1'b1;
                            state_next    = ST_EMIT;
                        end else if (id_reg != pfibh_pkg::BUCKET_ID && bkt_reg
                                     && !clean_reg[hit_f_reg]) begin
                            if (clean_reg[bkt_f_reg]) begin
                                zrow_next  = bkt_f_reg;
                                ret_next   = ST_FOLD_SRC;
                                state_next = ST_ZSWEEP;
                            end else begin
                                state_next = ST_FOLD_SRC;
                            end
                        end else begin
                            valid_next[hit_f_reg] = 1'b0;
                            keys_next[hit_f_reg]  = '0;
                            clean_next[hit_f_reg] = 1'b1;
                            m_valid_next = 1'b1;
                            state_next   = ST_EMIT;
                        end
                    end
                    pfibh_pkg::OP_ADD: begin
                        if (!hit_reg) begin
                            m_status_next = pfibh_pkg::STATUS_UNKNOWN;
                            m_valid_next  = 1'b1;
                            state_next    = ST_EMIT;
                        end else if (clean_reg[hit_f_reg]) begin
                            zrow_next  = hit_f_reg;
                            ret_next   = ST_ADD_RD;
                            state_next = ST_ZSWEEP;
                        end else begin
                            state_next = ST_ADD_RD;
                        end
                    end
                    pfibh_pkg::OP_TICK: begin
                        cur_next   = (cur_inc >= n7) ? '0 : SW'(cur_inc);
                        state_next = ST_TICK;
                    end
                    pfibh_pkg::OP_QUERY_FLOW: begin
                        status_next = hit_reg ? pfibh_pkg::STATUS_OK : pfibh_pkg::STATUS_UNKNOWN;
                        s_next      = cur_inc;
                        ret_next    = ST_QF_RD;
                        state_next  = ST_REDUCE;
                    end
                    pfibh_pkg::OP_QUERY_ALL: begin
                        status_next = pfibh_pkg::STATUS_OK;
                        s_next      = cur_inc;
                        ret_next    = ST_QT_RD;
                        state_next  = ST_REDUCE;
                    end
                    pfibh_pkg::OP_CLEAR_ALL: begin
                        valid_next = '0;
                        clean_next = '1;
                        for (int f = 0; f < MAX_FLOWS; f++) begin
                            keys_next[f] = '0;
                        end
                        m_valid_next = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    default: begin
                        m_valid_next = 1'b1;
                        state_next   = ST_EMIT;
                    end
                endcase
            end
            ST_ZSWEEP: begin
                we    = 1'b1;
                waddr = {zrow_reg, cnt_reg[SW-1:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MAX_SLOTS - 1)) begin
                    clean_next[zrow_reg] = 1'b0;
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end
            ST_ADD_RD: begin
                raddr      = {hit_f_reg, cur_reg};
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                we    = 1'b1;
                waddr = {hit_f_reg, cur_reg};
                wdata = rdata_reg + bytes_reg;
                m_valid_next = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_FOLD_SRC: begin
                raddr      = {hit_f_reg, cnt_reg[SW-1:0]};
                state_next = ST_FOLD_DST;
            end
            ST_FOLD_DST: begin
                raddr      = {bkt_f_reg, cnt_reg[SW-1:0]};
                src_next   = rdata_reg;
                state_next = ST_FOLD_WR;
            end
            ST_FOLD_WR: begin
                we    = 1'b1;
                waddr = {bkt_f_reg, cnt_reg[SW-1:0]};
                wdata = rdata_reg + src_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == n_c - 1'b1) begin
                    valid_next[hit_f_reg] = 1'b0;
                    keys_next[hit_f_reg]  = '0;
                    clean_next[hit_f_reg] = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_FOLD_SRC;
                end
            end
            ST_TICK: begin
                // clean rings already read as zero
                we    = valid_reg[scan_idx] && !clean_reg[scan_idx];
                waddr = {scan_idx, cur_reg};
                scan_next = scan_reg + 1'b1;
                if (scan_last) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_REDUCE: begin
                if (s_reg >= n7) begin
                    s_next = s_reg - n7;
                end else begin
                    pos_next   = 6'd1;
                    sum_next   = '0;
                    scan_next  = '0;
                    state_next = ret_reg;
                end
            end
            ST_QF_RD: begin
                raddr      = {hit_f_reg, SW'(s_reg)};
                state_next = ST_QF_DAT;
            end
            ST_QF_DAT: begin
                m_total_next  = (hit_reg && !clean_reg[hit_f_reg]) ? rdata_reg : '0;
                m_pos_next    = pos_reg;
                m_status_next = status_reg;
                m_last_next   = q_last;
                m_valid_next  = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_QT_RD: begin
                raddr      = {scan_idx, SW'(s_reg)};
                state_next = ST_QT_ACC;
            end
            ST_QT_ACC: begin
                if (valid_reg[scan_idx] && !clean_reg[scan_idx]) begin
                    sum_next = sum_reg + rdata_reg;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_last) begin
                    m_total_next  = (valid_reg[scan_idx] && !clean_reg[scan_idx])
                                    ? sum_reg + rdata_reg : sum_reg;
                    m_pos_next    = pos_reg;
                    m_status_next = status_reg;
                    m_last_next   = q_last;
                    m_valid_next  = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    state_next = ST_QT_RD;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 6'd1;
                        s_next     = (s_inc == n7) ? '0 : s_inc;
                        sum_next   = '0;
                        scan_next  = '0;
                        state_next = ret_reg;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            valid_reg   <= MAX_FLOWS'(1);
            clean_reg   <= '1;
            cur_reg     <= '0;
            cfg_reg     <= pfibh_pkg::INTERVALS_DEFAULT;
            m_valid_reg <= 1'b0;
            for (int f = 0; f < MAX_FLOWS; f++) begin
                keys_reg[f] <= (f == 0) ? pfibh_pkg::BUCKET_ID : '0;
            end
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            valid_reg   <= valid_next;
            clean_reg   <= clean_next;
            cur_reg     <= cur_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
            keys_reg    <= keys_next;
        end
        op_reg       <= op_next;
        id_reg       <= id_next;
        bytes_reg    <= bytes_next;
        scan_reg     <= scan_next;
        hit_reg      <= hit_next;
        hit_f_reg    <= hit_f_next;
        free_reg     <= free_next;
        free_f_reg   <= free_f_next;
        bkt_reg      <= bkt_next;
        bkt_f_reg    <= bkt_f_next;
        zrow_reg     <= zrow_next;
        cnt_reg      <= cnt_next;
        s_reg        <= s_next;
        pos_reg      <= pos_next;
        sum_reg      <= sum_next;
        src_reg      <= src_next;
        status_reg   <= status_next;
        m_last_reg   <= m_last_next;
        m_total_reg  <= m_total_next;
        m_pos_reg    <= m_pos_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[waddr] <= wdata;
        end
        rdata_reg <= slot_mem[raddr];
    end

    `PFIBH_NEVER(a_idle_no_result, aclk, aresetn, s_tready && m_tvalid, "ready with result")
    `PFIBH_NEVER(a_full_single, aclk, aresetn, m_tvalid && m_tuser == 2'd2 && !m_tlast, "full")
    `PFIBH_ASSERT(a_mid_has_pos, aclk, aresetn, (m_tvalid && !m_tlast) |-> (m_tdata[37:32] != 6'd0), "no pos")
    `PFIBH_ASSERT(a_pos_steps, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> !m_tvalid, "early beat")

endmodule

### sim/pfibh_history_checker.sv
// Scoreboard for the flow history unit: tracks flow table and rings, checks every result beat.
module pfibh_history_checker
    import pfibh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // flow_id[31:0], byte_count[63:32]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // slot_total[31:0], slot_position[37:32], zero pad
    input  logic [1:0]  m_tuser,   // status[1:0]
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FLOWS = 16;
    localparam int SLOTS = 64;

    typedef struct packed {
        logic [31:0] total;
        logic [5:0]  position;
        logic [1:0]  status;
        logic        last;
    } slot_result_t;

    logic [31:0]  flow_key   [FLOWS];
    logic         flow_live  [FLOWS];
    logic [31:0]  ring       [FLOWS][SLOTS];
    int           cur_slot;
    logic [6:0]   intervals;
    slot_result_t awaited[$];

    function automatic int span_len();
        int n;
        n = intervals;
        if (n < 2) n = 2;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    function automatic int lookup_flow(logic [31:0] id);
        for (int f = 0; f < FLOWS; f++)
            if (flow_live[f] && flow_key[f] == id) return f;
        return -1;
    endfunction

    function automatic void wipe_ring(int f);
        for (int s = 0; s < SLOTS; s++) ring[f][s] = '0;
    endfunction

    function automatic void reset_tables();
        for (int f = 0; f < FLOWS; f++) begin
            flow_key[f]  = '0;
            flow_live[f] = 1'b0;
            wipe_ring(f);
        end
        flow_key[0]  = BUCKET_ID;
        flow_live[0] = 1'b1;
        cur_slot     = 0;
        intervals    = INTERVALS_DEFAULT;
        awaited.delete();
    endfunction

    // Works out the result beats of one accepted operation and queues them.
    function automatic void predict_history(logic [2:0] op, logic [31:0] id, logic [31:0] bytes);
        int n, f, g;
        logic [1:0]  st;
        logic [31:0] sum;
        slot_result_t r;
        n  = span_len();
        st = STATUS_OK;
        case (op)
            OP_REGISTER: begin
                f = lookup_flow(id);
                if (f < 0) begin
                    for (g = 0; g < FLOWS && f < 0; g++)
                        if (!flow_live[g]) f = g;
                    if (f >= 0) begin
                        flow_live[f] = 1'b1;
                        flow_key[f]  = id;
                    end
                end
                if (f < 0) st = STATUS_FULL;
                else wipe_ring(f);
            end
            OP_UNREGISTER: begin
                f = lookup_flow(id);
                if (f < 0) begin
                    st = STATUS_UNKNOWN;
                end else begin
                    g = (id != BUCKET_ID) ? lookup_flow(BUCKET_ID) : -1;
                    if (g >= 0)
                        for (int s = 0; s < n; s++) ring[g][s] = ring[g][s] + ring[f][s];
                    flow_live[f] = 1'b0;
                    flow_key[f]  = '0;
                    wipe_ring(f);
                end
            end
            OP_ADD: begin
                f = lookup_flow(id);
                if (f < 0) st = STATUS_UNKNOWN;
                else ring[f][cur_slot % SLOTS] = ring[f][cur_slot % SLOTS] + bytes;
            end
            OP_TICK: begin
                cur_slot = cur_slot + 1;
                if (cur_slot >= n) cur_slot = 0;
                for (f = 0; f < FLOWS; f++)
                    if (flow_live[f]) ring[f][cur_slot] = '0;
            end
            OP_QUERY_FLOW, OP_QUERY_ALL: begin
                f = -1;
                if (op == OP_QUERY_FLOW) begin
                    f = lookup_flow(id);
                    if (f < 0) st = STATUS_UNKNOWN;
                end
                for (int p = 1; p < n; p++) begin
                    int s;
                    s   = (cur_slot + p) % n;
                    sum = '0;
                    if (op == OP_QUERY_FLOW) begin
                        if (f >= 0) sum = ring[f][s];
                    end else begin
                        for (g = 0; g < FLOWS; g++)
                            if (flow_live[g]) sum = sum + ring[g][s];
                    end
                    r = '{total: sum, position: p[5:0], status: st, last: (p == n - 1)};
                    awaited.push_back(r);
                end
                return;
            end
            OP_CLEAR_ALL: begin
                for (f = 0; f < FLOWS; f++) begin
                    flow_live[f] = 1'b0;
                    flow_key[f]  = '0;
                    wipe_ring(f);
                end
            end
            default: ;
        endcase
        r = '{total: '0, position: '0, status: st, last: 1'b1};
        awaited.push_back(r);
    endfunction

    initial begin
        fail_count    = 0;
        beats_checked = 0;
        pending       = 0;
        reset_tables();
    end

    always @(posedge aclk) begin
        slot_result_t want, got;
        if (!aresetn) begin
            reset_tables();
        end else begin
            // results first: a beat leaving now belongs to an earlier operation
            if (m_tvalid && m_tready) begin
                got = '{total: m_tdata[31:0], position: m_tdata[37:32],
                        status: m_tuser, last: m_tlast};
                beats_checked++;
                if (awaited.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result beat total=%h pos=%0d st=%0d last=%b",
                                 $realtime, got.total, got.position, got.status, got.last);
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp total=%h pos=%0d st=%0d last=%b, got total=%h pos=%0d st=%0d last=%b",
                                     $realtime, want.total, want.position, want.status, want.last,
                                     got.total, got.position, got.status, got.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) intervals = cfg_data;
            if (s_tvalid && s_tready)
                predict_history(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
        pending = awaited.size();
    end

endmodule

### sim/tb_per_flow_interval_byte_history_unit.sv
// Testbench top: clock, reset, operation stimulus and verdict for the flow history unit.
module tb_per_flow_interval_byte_history_unit;
    import pfibh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RESERVED = 3'd7;
    localparam int         CYCLE_LIMIT = 10_000_000;
    localparam int         POOL_SIZE   = 18;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [63:0] s_tdata;   // flow_id[31:0], byte_count[63:32]
    logic [2:0]  s_tuser;   // operation[2:0]
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;   // slot_total[31:0], slot_position[37:32], zero pad
    logic [1:0]  m_tuser;   // status[1:0]
    logic        m_tlast;
    logic        cfg_valid, cfg_ready;
    logic [6:0]  cfg_data;

    int fail_count, pending, beats_checked;
    int cycles;
    int ops_sent;
    int settings_used;
    bit calm;
    bit hold_req;
    logic [31:0] id_pool [POOL_SIZE];

    per_flow_interval_byte_history_unit u_top (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    pfibh_history_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_data,
        .fail_count, .pending, .beats_checked
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL per_flow_interval_byte_history_unit");
            $finish;
        end
    end

    // Receiver: mostly ready, short and occasional long stalls, plus one requested hold-off.
    initial begin
        int stall_left;
        int pick;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 84) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall_left = (pick < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_op(logic [2:0] op, logic [31:0] id, logic [31:0] bytes);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bytes, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ops_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_intervals(logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [31:0] random_id();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 90) return BUCKET_ID;
        return $urandom;
    endfunction

    function automatic logic [31:0] random_bytes();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom;
    endfunction

    // Weighted so that the table fills and drains; clear all and the reserved code are rare.
    task automatic send_random();
        int pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if      (pick < 22) op = OP_REGISTER;
        else if (pick < 31) op = OP_UNREGISTER;
        else if (pick < 63) op = OP_ADD;
        else if (pick < 77) op = OP_TICK;
        else if (pick < 88) op = OP_QUERY_FLOW;
        else if (pick < 95) op = OP_QUERY_ALL;
        else if (pick < 97) op = OP_CLEAR_ALL;
        else                op = OP_RESERVED;
        send_op(op, random_id(), random_bytes());
    endtask

    initial begin
        logic [6:0]  settings [9];
        logic [31:0] flow_a, flow_b;
        settings = '{7'd0, 7'd127, 7'd5, 7'd64, 7'd2, 7'd33, 7'd1, 7'd9, 7'd100};
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        ops_sent      = 0;
        settings_used = 1;
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
        id_pool[0] = 32'h0000_0000;
        flow_a = 32'h0000_0000;
        flow_b = 32'h8000_0001;

        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset interval count
        send_op(OP_QUERY_FLOW, flow_a, '0);
        send_op(OP_UNREGISTER, 32'h1234_5678, '0);
        send_op(OP_ADD, flow_b, 32'd7);
        send_op(OP_REGISTER, flow_a, '0);
        send_op(OP_REGISTER, flow_b, '0);
        send_op(OP_ADD, flow_a, '1);
        send_op(OP_ADD, flow_a, 32'd2);           // wraps
        send_op(OP_ADD, flow_b, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_ADD, flow_b, '1);
        send_op(OP_TICK, '0, '0);
        send_op(OP_QUERY_FLOW, flow_a, '0);
        send_op(OP_QUERY_ALL, '0, '0);
        send_op(OP_REGISTER, flow_a, '0);         // known id: ring zeroed
        send_op(OP_QUERY_FLOW, flow_a, '0);
        send_op(OP_UNREGISTER, flow_b, '0);       // folds into the bucket
        send_op(OP_QUERY_FLOW, BUCKET_ID, '0);
        send_op(OP_UNREGISTER, BUCKET_ID, '0);
        send_op(OP_ADD, flow_a, 32'h5555_AAAA);
        send_op(OP_UNREGISTER, flow_a, '0);       // no bucket to fold into
        send_op(OP_REGISTER, BUCKET_ID, '0);
        send_op(OP_CLEAR_ALL, '0, '0);
        send_op(OP_QUERY_ALL, '0, '0);            // empty table
        send_op(OP_RESERVED, '1, '1);
        send_op(OP_TICK, '0, '0);
        settle();

        foreach (settings[k]) begin
            write_intervals(settings[k]);
            calm = (k % 3 == 2);
            if (k == 1) begin
                // receiver holds off while a back-to-back burst queues up behind it
                hold_req = 1'b1;
                calm     = 1'b1;
                repeat (12) send_random();
                calm = 1'b0;
            end
            repeat (22) send_random();
            calm = 1'b0;
            settle();
        end

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d operations over %0d interval settings (0 to 127), %0d result beats",
                 ops_sent, settings_used, beats_checked);
        $display("checked against the flow table and ring prediction.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS per_flow_interval_byte_history_unit");
        end else begin
            $display("FAIL per_flow_interval_byte_history_unit");
        end
        $finish;
    end

endmodule
